FILE: sv/lkcp_pkg.sv
// Package for the longest k-change palindrome block.
// Holds the transfer payload types, the controller states and the register map.
// Depends on nothing.
`default_nettype none

package lkcp_pkg;

  localparam int unsigned MaxChangesW = 11;
  localparam int unsigned BestLenW    = 11;
  localparam int unsigned CountW      = MaxChangesW + 1;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 32;

  localparam logic [CfgAddrW-3:0] RegMaxChanges = '0;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic [BestLenW-1:0] best_length;
    logic                overflow;
  } result_t;

  typedef enum logic [1:0] {
    StIdle,
    StIssue,
    StCompare
  } state_e;

endpackage

`default_nettype wire

FILE: sv/longest_k_change_palindrome.sv
// Top level of the longest k-change palindrome block: byte store, search controller and
// APB register port. Depends on lkcp_pkg.
//
// A string is loaded one byte per cycle while busy_o is low; the transfer with last_char set
// starts the search and busy_o rises. The search expands around every centre, reading two
// bytes from the text store per step; each step has an issue state (address) and then a compare
// state, because the read from the text store is registered. The result appears on result_o
// with done_o high for exactly one cycle; it cannot be held off, and busy_o falls in that
// same cycle. Bytes beyond MAX_LEN are dropped and reported through the overflow field.
`default_nettype none

module longest_k_change_palindrome #(
  parameter int unsigned MAX_LEN = 1024
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  lkcp_pkg::item_t         item_i,
  output logic                          busy_o,
  output logic                          done_o,
  output lkcp_pkg::result_t             result_o,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [lkcp_pkg::CfgAddrW-1:0] paddr,
  input  wire  [lkcp_pkg::CfgDataW-1:0] pwdata,
  output logic [lkcp_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic [lkcp_pkg::MaxChangesW-1:0] max_changes_q;
  logic                             cfg_wr;

  lkcp_pkg::state_e state_q, state_d;

  logic [7:0]    mem_q [MAX_LEN];
  logic [7:0]    rd_lo_q, rd_hi_q;
  logic          wr_en;

  logic [LW-1:0] len_q, len_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] ctr_q, ctr_d;
  logic [AW-1:0] lo_q, lo_d;
  logic [AW-1:0] hi_q, hi_d;
  logic          odd_q, odd_d;
  logic [lkcp_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] best_q, best_d;
  logic          done_q, done_d;
  lkcp_pkg::result_t res_q, res_d;

  logic                        accept;
  logic [lkcp_pkg::CountW-1:0] cnt_new;
  logic [LW-1:0]               win;
  logic [LW-1:0]               best_upd;
  logic                        next_ctr_in;
  logic                        at_edge;
  logic                        over;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[lkcp_pkg::CfgAddrW-1:2] == lkcp_pkg::RegMaxChanges);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_changes_q <= '0;
    end else if (cfg_wr) begin
      max_changes_q <= pwdata[lkcp_pkg::MaxChangesW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[lkcp_pkg::CfgAddrW-1:2] == lkcp_pkg::RegMaxChanges) begin
      prdata = lkcp_pkg::CfgDataW'(max_changes_q);
    end
  end

  // Text store.
  assign accept = start_i && !busy_o;
  assign wr_en  = accept && (len_q < LW'(MAX_LEN));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q[AW-1:0]] <= item_i.char_in;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_lo_q <= mem_q[lo_q];
    rd_hi_q <= mem_q[hi_q];
  end

  // Search datapath.
  assign cnt_new     = cnt_q + lkcp_pkg::CountW'(rd_lo_q != rd_hi_q);
  assign over        = cnt_new > lkcp_pkg::CountW'(max_changes_q);
  assign win         = LW'(hi_q - lo_q) + LW'(1);
  assign best_upd    = (win > best_q) ? win : best_q;
  assign at_edge     = (lo_q == '0) || ((LW'(hi_q) + LW'(1)) >= len_q);
  assign next_ctr_in = (LW'(ctr_q) + LW'(1)) < len_q;

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    ovf_d   = ovf_q;
    ctr_d   = ctr_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    odd_d   = odd_q;
    cnt_d   = cnt_q;
    best_d  = best_q;
    done_d  = 1'b0;
    res_d   = res_q;

    case (state_q)
      lkcp_pkg::StIdle: begin
        if (accept) begin
          if (wr_en) begin
            len_d = len_q + LW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (item_i.last_char) begin
            ctr_d   = '0;
            lo_d    = '0;
            hi_d    = '0;
            odd_d   = 1'b1;
            cnt_d   = '0;
            best_d  = '0;
            state_d = lkcp_pkg::StIssue;
          end
        end
      end
      lkcp_pkg::StIssue: begin
        state_d = lkcp_pkg::StCompare;
      end
      lkcp_pkg::StCompare: begin
        cnt_d = cnt_new;
        if (!over) begin
          best_d = best_upd;
        end
        if (!over && !at_edge) begin
          lo_d    = lo_q - AW'(1);
          hi_d    = hi_q + AW'(1);
          state_d = lkcp_pkg::StIssue;
        end else if (odd_q && next_ctr_in) begin
          lo_d    = ctr_q;
          hi_d    = ctr_q + AW'(1);
          odd_d   = 1'b0;
          cnt_d   = '0;
          state_d = lkcp_pkg::StIssue;
        end else if (!odd_q) begin
          ctr_d   = ctr_q + AW'(1);
          lo_d    = ctr_q + AW'(1);
          hi_d    = ctr_q + AW'(1);
          odd_d   = 1'b1;
          cnt_d   = '0;
          state_d = lkcp_pkg::StIssue;
        end else begin
          done_d            = 1'b1;
          res_d.best_length = lkcp_pkg::BestLenW'(over ? best_q : best_upd);
          res_d.overflow    = ovf_q;
          len_d             = '0;
          ovf_d             = 1'b0;
          cnt_d             = '0;
          best_d            = '0;
          state_d           = lkcp_pkg::StIdle;
        end
      end
      default: begin
        state_d = lkcp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkcp_pkg::StIdle;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      ctr_q   <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      odd_q   <= 1'b1;
      cnt_q   <= '0;
      best_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      ctr_q   <= ctr_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      odd_q   <= odd_d;
      cnt_q   <= cnt_d;
      best_q  <= best_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o   = (state_q != lkcp_pkg::StIdle);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire
